// ----- src/itt_pkg.sv -----
// Package for the INI text tokenizer: transfer types, state flags,
// destination codes, error bits and character constants.
// No dependencies; every other file refers to it by scoped names.
package itt_pkg;

	// Input transfer: one text byte or an end-of-file marker
	typedef struct packed {
		logic       command;
		logic [7:0] data_byte;
	} in_item_t;

	// Output transfer: one classified character plus markers
	typedef struct packed {
		logic [7:0] char_out;
		logic [1:0] char_dest;
		logic       section_start;
		logic       entry_done;
		logic [4:0] error_flags;
	} out_item_t;

	// Lexer state carried from byte to byte
	typedef struct packed {
		logic escape_pending;
		logic comment_skip;
		logic in_section_header;
		logic header_closed_this_line;
		logic on_value_side;
		logic in_quotes;
		logic key_nonempty;
		logic value_nonempty;
	} lex_state_t;

	// Handshake control between the input and output stages
	typedef struct packed {
		logic advance;
	} stage_ctl_t;

	// Command codes
	localparam logic CMD_DATA = 1'b0;
	localparam logic CMD_EOF  = 1'b1;

	// Destination codes
	localparam logic [1:0] DEST_NONE    = 2'd0;
	localparam logic [1:0] DEST_SECTION = 2'd1;
	localparam logic [1:0] DEST_KEY     = 2'd2;
	localparam logic [1:0] DEST_VALUE   = 2'd3;

	// Error flag bits
	localparam logic [4:0] ERR_NESTED_OPEN       = 5'b00001;
	localparam logic [4:0] ERR_STRAY_CLOSE       = 5'b00010;
	localparam logic [4:0] ERR_KEY_NO_VALUE      = 5'b00100;
	localparam logic [4:0] ERR_KEY_AFTER_SECTION = 5'b01000;
	localparam logic [4:0] ERR_OPEN_AT_EOF       = 5'b10000;

	// Special characters
	localparam logic [7:0] CH_OPEN   = 8'h5B; // [
	localparam logic [7:0] CH_CLOSE  = 8'h5D; // ]
	localparam logic [7:0] CH_SEMI   = 8'h3B; // ;
	localparam logic [7:0] CH_EQUALS = 8'h3D; // =
	localparam logic [7:0] CH_BSLASH = 8'h5C; // backslash
	localparam logic [7:0] CH_QUOTE  = 8'h22; // double quote
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BEL    = 8'h07;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_LOW_A  = 8'h61;
	localparam logic [7:0] CH_LOW_B  = 8'h62;
	localparam logic [7:0] CH_LOW_T  = 8'h74;
	localparam logic [7:0] CH_LOW_R  = 8'h72;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;

endpackage

// ----- src/itt_in_stage.sv -----
// Input register of the INI text tokenizer: holds one accepted byte
// transfer until the lexer hands its result to the output stage.
// Depends on itt_pkg.
module itt_in_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  itt_pkg::in_item_t    byte_item,
	input  logic                 out_ready,
	output itt_pkg::in_item_t    item_s1,
	output itt_pkg::stage_ctl_t  ctl
);

	logic load;
	logic valid_s1;

	// Advance when the held byte can move into the output register
	assign ctl.advance   = valid_s1 & out_ready;
	assign byte_stall    = valid_s1 & ~out_ready;
	assign load          = byte_valid & ~byte_stall;

	// Hold the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (ctl.advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the payload on each accepted transfer
	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= byte_item;
		end
	end

endmodule

// ----- src/itt_lexer.sv -----
// Lexer core of the INI text tokenizer: state flags and the per-byte
// classification, escape translation and error detection.
// Depends on itt_pkg.
module itt_lexer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  itt_pkg::in_item_t    item_s1,
	input  itt_pkg::stage_ctl_t  ctl,
	output itt_pkg::out_item_t   result
);

	itt_pkg::lex_state_t st_q;
	itt_pkg::lex_state_t st_nxt;
	logic                emit;
	logic [7:0]          emit_ch;
	logic [7:0]          b;

	assign b = item_s1.data_byte;

	// Work out next state and the result for the held byte
	always_comb begin
		st_nxt  = st_q;
		result  = '0;
		emit    = 1'b0;
		emit_ch = b;
		if (item_s1.command == itt_pkg::CMD_EOF) begin
			// End of text: report open header or dangling key, then restart
			if (st_q.in_section_header) begin
				result.error_flags = result.error_flags | itt_pkg::ERR_OPEN_AT_EOF;
			end
			if (st_q.key_nonempty && !st_q.on_value_side) begin
				result.error_flags = result.error_flags | itt_pkg::ERR_KEY_NO_VALUE;
			end
			result.entry_done = ~st_q.in_section_header & st_q.key_nonempty
				& st_q.value_nonempty;
			st_nxt = '0;
		end else begin
			unique case (b)
				itt_pkg::CH_QUOTE: begin
					st_nxt.in_quotes = ~st_q.in_quotes;
					emit = 1'b1;
				end
				itt_pkg::CH_TAB, itt_pkg::CH_CR, itt_pkg::CH_SPACE: begin
					emit = st_q.in_quotes;
				end
				itt_pkg::CH_OPEN: begin
					if (st_q.escape_pending) begin
						emit = 1'b1;
					end else if (!st_q.comment_skip) begin
						if (st_q.in_section_header) begin
							result.error_flags = itt_pkg::ERR_NESTED_OPEN;
						end
						st_nxt.in_section_header = 1'b1;
						result.section_start = 1'b1;
					end
				end
				itt_pkg::CH_CLOSE: begin
					if (st_q.escape_pending) begin
						emit = 1'b1;
					end else if (!st_q.comment_skip) begin
						if (!st_q.in_section_header) begin
							result.error_flags = itt_pkg::ERR_STRAY_CLOSE;
						end
						st_nxt.in_section_header       = 1'b0;
						st_nxt.header_closed_this_line = 1'b1;
					end
				end
				itt_pkg::CH_SEMI: begin
					if (st_q.escape_pending) begin
						emit = 1'b1;
					end else begin
						st_nxt.comment_skip = 1'b1;
					end
				end
				itt_pkg::CH_LF: begin
					if (st_q.escape_pending) begin
						st_nxt.escape_pending = 1'b0;
					end else begin
						if (st_q.key_nonempty && !st_q.on_value_side) begin
							result.error_flags = itt_pkg::ERR_KEY_NO_VALUE;
						end
						st_nxt.comment_skip            = 1'b0;
						st_nxt.header_closed_this_line = 1'b0;
						st_nxt.on_value_side           = 1'b0;
						if (!st_q.in_section_header && st_q.key_nonempty
								&& st_q.value_nonempty) begin
							result.entry_done     = 1'b1;
							st_nxt.key_nonempty   = 1'b0;
							st_nxt.value_nonempty = 1'b0;
						end
					end
				end
				itt_pkg::CH_EQUALS: begin
					if (!st_q.comment_skip) begin
						if (!st_q.in_section_header) begin
							st_nxt.on_value_side = ~st_q.on_value_side;
						end else begin
							emit = 1'b1;
						end
					end
				end
				itt_pkg::CH_BSLASH: begin
					if (st_q.escape_pending) begin
						emit = 1'b1;
					end else begin
						st_nxt.escape_pending = 1'b1;
					end
				end
				itt_pkg::CH_LOW_A: begin
					emit    = 1'b1;
					emit_ch = st_q.escape_pending ? itt_pkg::CH_BEL : b;
				end
				itt_pkg::CH_LOW_B: begin
					emit    = 1'b1;
					emit_ch = st_q.escape_pending ? itt_pkg::CH_BS : b;
				end
				itt_pkg::CH_LOW_T: begin
					emit    = 1'b1;
					emit_ch = st_q.escape_pending ? itt_pkg::CH_TAB : b;
				end
				itt_pkg::CH_LOW_R: begin
					emit    = 1'b1;
					emit_ch = st_q.escape_pending ? itt_pkg::CH_CR : b;
				end
				itt_pkg::CH_LOW_N: begin
					emit    = 1'b1;
					emit_ch = st_q.escape_pending ? itt_pkg::CH_LF : b;
				end
				default: begin
					emit = 1'b1;
				end
			endcase

			// Append an ordinary character unless inside a comment
			if (emit && !st_q.comment_skip) begin
				st_nxt.escape_pending = 1'b0;
				if (st_q.header_closed_this_line) begin
					result.error_flags = result.error_flags
						| itt_pkg::ERR_KEY_AFTER_SECTION;
				end
				result.char_out = emit_ch;
				if (st_q.in_section_header) begin
					result.char_dest = itt_pkg::DEST_SECTION;
				end else if (st_q.on_value_side) begin
					result.char_dest      = itt_pkg::DEST_VALUE;
					st_nxt.value_nonempty = 1'b1;
				end else begin
					result.char_dest    = itt_pkg::DEST_KEY;
					st_nxt.key_nonempty = 1'b1;
				end
			end
		end
	end

	// Commit state when the byte moves on to the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (ctl.advance) begin
			st_q <= st_nxt;
		end
	end

endmodule

// ----- src/itt_out_stage.sv -----
// Output register of the INI text tokenizer: holds one result transfer
// while the receiver stalls and frees itself as it drains.
// Depends on itt_pkg.
module itt_out_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  itt_pkg::stage_ctl_t  ctl,
	input  itt_pkg::out_item_t   result,
	output logic                 out_ready,
	output logic                 tok_valid,
	input  logic                 tok_stall,
	output itt_pkg::out_item_t   tok_item
);

	logic                valid_s2;
	itt_pkg::out_item_t  item_s2;

	// Free for a new result when empty or draining this cycle
	assign out_ready = ~valid_s2 | ~tok_stall;
	assign tok_valid = valid_s2;
	assign tok_item  = item_s2;

	// Hold the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ctl.advance) begin
			valid_s2 <= 1'b1;
		end else if (!tok_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	// Load the result; a stalled result holds
	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			item_s2 <= result;
		end
	end

endmodule

// ----- src/ini_text_tokenizer.sv -----
// INI text tokenizer top level: input register, lexer core, output register.
// Depends on itt_pkg, itt_in_stage, itt_lexer and itt_out_stage.
//
// Usage:
//   byte channel (byte_valid, byte_stall, byte_item) carries one text byte
//   or an end-of-file marker per transfer. tok channel (tok_valid,
//   tok_stall, tok_item) returns exactly one classified result per input
//   transfer, in order.
//   A byte accepted into the input register is classified by the lexer and
//   loaded into the output register, where tok_valid rises; the result is
//   held there until the receiver takes it.
//   Throughput: one byte per cycle while tok_stall stays low, set by the
//   single lexer state update between the input and output registers.
//   Reset (arst_n low) empties both registers and clears all lexer flags;
//   an end-of-file transfer also returns the lexer flags to that state.
//   While tok_stall is high the result holds; the input register still
//   takes one more byte, then byte_stall rises until the result drains.
module ini_text_tokenizer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  itt_pkg::in_item_t  byte_item,
	output logic               tok_valid,
	input  logic               tok_stall,
	output itt_pkg::out_item_t tok_item
);

	logic                 out_ready;
	itt_pkg::in_item_t    item_s1;
	itt_pkg::stage_ctl_t  ctl;
	itt_pkg::out_item_t   result;

	itt_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.out_ready  (out_ready),
		.item_s1    (item_s1),
		.ctl        (ctl)
	);

	itt_lexer u_lexer (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_s1 (item_s1),
		.ctl     (ctl),
		.result  (result)
	);

	itt_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.result    (result),
		.out_ready (out_ready),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok_item  (tok_item)
	);

endmodule
